FILE: sv/point_in_polygon_test_defines.svh
// Assertion macros shared by the point-in-polygon checker.
`ifndef POINT_IN_POLYGON_TEST_DEFINES_SVH
`define POINT_IN_POLYGON_TEST_DEFINES_SVH

// Property checked at every clock edge, also while reset is held.
`define PIP_CHECK(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

// Property checked only while reset is released.
`define PIP_CHECK_RUN(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

`endif

FILE: sv/pip_pkg.sv
// Types and constants shared by the point-in-polygon modules.
`timescale 1ns / 1ps

package pip_pkg;

    typedef enum logic [1:0] {
        FN_START  = 2'd0,
        FN_APPEND = 2'd1,
        FN_QUERY  = 2'd2
    } t_func;

    typedef enum logic [1:0] {
        S_IDLE,
        S_WALK,
        S_DONE
    } t_state;

    // Head of the queue between the front and back parts.
    typedef struct packed {
        logic  valid;
        t_func func;
    } t_head;

    localparam int Q_DEPTH = 2;
    localparam int Q_AW    = $clog2(Q_DEPTH);

endpackage

FILE: sv/pip_front.sv
// Front part: accepts items, drops unused codes and queues the rest.
`timescale 1ns / 1ps

module pip_front
    import pip_pkg::*;
#(
    parameter int COORD_BITS = 16
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_stall,
    input  logic [1:0]                   i_func,
    input  logic signed [COORD_BITS-1:0] i_coord_x,
    input  logic signed [COORD_BITS-1:0] i_coord_y,
    output t_head                        o_head,
    output logic signed [COORD_BITS-1:0] o_head_x,
    output logic signed [COORD_BITS-1:0] o_head_y,
    input  logic                         i_pop
);

    localparam int FILL_BITS = $clog2(Q_DEPTH + 1);

    t_func                         r_q_func [Q_DEPTH];
    logic signed [COORD_BITS-1:0]  r_q_x    [Q_DEPTH];
    logic signed [COORD_BITS-1:0]  r_q_y    [Q_DEPTH];
    logic [Q_AW-1:0]               r_wr_ptr;
    logic [Q_AW-1:0]               r_rd_ptr;
    logic [FILL_BITS-1:0]          r_fill;
    logic [FILL_BITS-1:0]          n_fill;
    logic                          code_ok;
    logic                          push;

    always_comb begin
        code_ok = i_func inside {FN_START, FN_APPEND, FN_QUERY};
    end

    assign o_stall = (r_fill == FILL_BITS'(Q_DEPTH));
    assign push    = i_valid && !o_stall && code_ok;

    always_comb begin
        n_fill = r_fill;
        if (push && !i_pop) begin
            n_fill = r_fill + FILL_BITS'(1);
        end else if (!push && i_pop) begin
            n_fill = r_fill - FILL_BITS'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_fill   <= '0;
        end else begin
            r_fill <= n_fill;
            if (push) begin
                r_wr_ptr <= r_wr_ptr + Q_AW'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + Q_AW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q_func[r_wr_ptr] <= t_func'(i_func);
            r_q_x[r_wr_ptr]    <= i_coord_x;
            r_q_y[r_wr_ptr]    <= i_coord_y;
        end
    end

    assign o_head.valid = (r_fill != '0);
    assign o_head.func  = r_q_func[r_rd_ptr];
    assign o_head_x     = r_q_x[r_rd_ptr];
    assign o_head_y     = r_q_y[r_rd_ptr];

endmodule

FILE: sv/pip_back.sv
// Back part: vertex store, bounding box and the pipelined edge walker.
`timescale 1ns / 1ps

module pip_back
    import pip_pkg::*;
#(
    parameter int MAX_VERTICES = 64,
    parameter int COORD_BITS   = 16
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  t_head                        i_head,
    input  logic signed [COORD_BITS-1:0] i_head_x,
    input  logic signed [COORD_BITS-1:0] i_head_y,
    output logic                         o_pop,
    output logic                         o_valid,
    input  logic                         i_stall,
    output logic                         o_inside_res
);

    localparam int AW = $clog2(MAX_VERTICES);
    localparam int CW = $clog2(MAX_VERTICES + 1);
    localparam int C  = COORD_BITS;
    localparam int PW = 2 * C + 2;

    t_state                 r_state;
    t_state                 n_state;

    logic signed [C-1:0]    r_mem_x [MAX_VERTICES];
    logic signed [C-1:0]    r_mem_y [MAX_VERTICES];

    logic [CW-1:0]          r_count;
    logic signed [C-1:0]    r_min_x;
    logic signed [C-1:0]    r_min_y;
    logic signed [C-1:0]    r_max_x;
    logic signed [C-1:0]    r_max_y;
    logic signed [C-1:0]    r_px;
    logic signed [C-1:0]    r_py;

    logic                   head_query;
    logic                   box_miss;
    logic                   store_full;
    logic                   do_start;
    logic                   do_append;
    logic                   walk_go;
    logic                   load_out;
    logic                   out_free;

    // Read issue stage.
    logic                   r_issue_on;
    logic [AW-1:0]          r_rd_addr;
    logic                   rd_last;
    logic                   r_rd_vld;
    logic                   r_rd_first;
    logic                   r_rd_last;
    logic signed [C-1:0]    r_rd_x;
    logic signed [C-1:0]    r_rd_y;

    // Edge forming stage.
    logic                   r_wrap;
    logic signed [C-1:0]    r_first_x;
    logic signed [C-1:0]    r_first_y;
    logic signed [C-1:0]    r_prev_x;
    logic signed [C-1:0]    r_prev_y;
    logic                   n_e_vld;
    logic                   r_e_vld;
    logic                   r_e_last;
    logic signed [C-1:0]    r_ax;
    logic signed [C-1:0]    r_ay;
    logic signed [C-1:0]    r_bx;
    logic signed [C-1:0]    r_by;

    // Classify and difference stage.
    logic                   swap;
    logic signed [C-1:0]    lx;
    logic signed [C-1:0]    ly;
    logic signed [C-1:0]    rx;
    logic signed [C-1:0]    ry;
    logic                   r_d_vld;
    logic                   r_d_last;
    logic                   r_d_span;
    logic                   r_d_below;
    logic                   r_d_above;
    logic signed [C:0]      r_sx;
    logic signed [C:0]      r_sy;
    logic signed [C:0]      r_tx;
    logic signed [C:0]      r_ty;

    // Product stage.
    logic                   r_m_vld;
    logic                   r_m_last;
    logic                   r_m_span;
    logic                   r_m_below;
    logic                   r_m_above;
    logic signed [PW-1:0]   r_p1;
    logic signed [PW-1:0]   r_p2;
    logic                   hit;

    logic                   r_parity;
    logic                   r_out_vld;
    logic                   r_out;

    assign head_query = i_head.valid && (i_head.func == FN_QUERY);
    assign box_miss   = (r_count == '0) ||
                        (i_head_x < r_min_x) || (i_head_x > r_max_x) ||
                        (i_head_y < r_min_y) || (i_head_y > r_max_y);
    assign store_full = (r_count >= CW'(MAX_VERTICES));
    assign out_free   = !r_out_vld || !i_stall;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (head_query) begin
                    n_state = box_miss ? S_DONE : S_WALK;
                end
            end
            S_WALK: begin
                if (r_m_vld && r_m_last) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_pop     = 1'b0;
        do_start  = 1'b0;
        do_append = 1'b0;
        walk_go   = 1'b0;
        load_out  = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_pop     = i_head.valid;
                do_start  = i_head.valid && (i_head.func == FN_START);
                do_append = i_head.valid && (i_head.func == FN_APPEND) && !store_full;
                walk_go   = head_query && !box_miss;
            end
            S_DONE: begin
                load_out = out_free;
            end
            default: begin
                o_pop = 1'b0;
            end
        endcase
    end

    assign rd_last = (CW'(r_rd_addr) == r_count - CW'(1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_count    <= '0;
            r_min_x    <= '0;
            r_min_y    <= '0;
            r_max_x    <= '0;
            r_max_y    <= '0;
            r_issue_on <= 1'b0;
            r_rd_addr  <= '0;
            r_rd_vld   <= 1'b0;
            r_wrap     <= 1'b0;
            r_e_vld    <= 1'b0;
            r_d_vld    <= 1'b0;
            r_m_vld    <= 1'b0;
            r_parity   <= 1'b0;
            r_out_vld  <= 1'b0;
        end else begin
            r_state <= n_state;

            if (do_start) begin
                r_count <= CW'(1);
                r_min_x <= i_head_x;
                r_max_x <= i_head_x;
                r_min_y <= i_head_y;
                r_max_y <= i_head_y;
            end else if (do_append) begin
                r_count <= r_count + CW'(1);
                if (r_count == '0) begin
                    r_min_x <= i_head_x;
                    r_max_x <= i_head_x;
                    r_min_y <= i_head_y;
                    r_max_y <= i_head_y;
                end else begin
                    if (i_head_x < r_min_x) r_min_x <= i_head_x;
                    if (i_head_x > r_max_x) r_max_x <= i_head_x;
                    if (i_head_y < r_min_y) r_min_y <= i_head_y;
                    if (i_head_y > r_max_y) r_max_y <= i_head_y;
                end
            end

            if (walk_go) begin
                r_issue_on <= 1'b1;
                r_rd_addr  <= '0;
            end else if (r_issue_on) begin
                r_rd_addr <= r_rd_addr + AW'(1);
                if (rd_last) begin
                    r_issue_on <= 1'b0;
                end
            end

            r_rd_vld <= r_issue_on;
            r_wrap   <= r_rd_vld && r_rd_last;
            r_e_vld  <= n_e_vld;
            r_d_vld  <= r_e_vld;
            r_m_vld  <= r_d_vld;

            if (o_pop && head_query) begin
                r_parity <= 1'b0;
            end else if (r_m_vld) begin
                r_parity <= r_parity ^ hit;
            end

            if (load_out) begin
                r_out_vld <= 1'b1;
            end else if (!i_stall) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // Vertex store: one write port, one registered read port.
    always_ff @(posedge i_clk) begin
        if (do_start) begin
            r_mem_x[0] <= i_head_x;
            r_mem_y[0] <= i_head_y;
        end else if (do_append) begin
            r_mem_x[r_count[AW-1:0]] <= i_head_x;
            r_mem_y[r_count[AW-1:0]] <= i_head_y;
        end
        if (r_issue_on) begin
            r_rd_x <= r_mem_x[r_rd_addr];
            r_rd_y <= r_mem_y[r_rd_addr];
        end
    end

    assign n_e_vld = (r_rd_vld && !r_rd_first) || r_wrap;

    always_comb begin
        swap = (r_ax > r_bx);
        lx   = swap ? r_bx : r_ax;
        ly   = swap ? r_by : r_ay;
        rx   = swap ? r_ax : r_bx;
        ry   = swap ? r_ay : r_by;
    end

    assign hit = r_m_span && !r_m_below && (r_m_above || (r_p1 < r_p2));

    always_ff @(posedge i_clk) begin
        if (o_pop && head_query) begin
            r_px <= i_head_x;
            r_py <= i_head_y;
        end
        if (r_issue_on) begin
            r_rd_first <= (r_rd_addr == '0);
            r_rd_last  <= rd_last;
        end

        if (r_rd_vld) begin
            r_prev_x <= r_rd_x;
            r_prev_y <= r_rd_y;
            if (r_rd_first) begin
                r_first_x <= r_rd_x;
                r_first_y <= r_rd_y;
            end
        end

        // The closing edge runs from the last vertex back to the first.
        r_e_last <= r_wrap;
        r_ax     <= r_prev_x;
        r_ay     <= r_prev_y;
        r_bx     <= r_wrap ? r_first_x : r_rd_x;
        r_by     <= r_wrap ? r_first_y : r_rd_y;

        r_d_last  <= r_e_last;
        r_d_span  <= (lx <= r_px) && (r_px < rx);
        r_d_below <= (ly < r_py) && (ry < r_py);
        r_d_above <= (ly >= r_py) && (ry >= r_py);
        r_sx      <= {rx[C-1], rx} - {lx[C-1], lx};
        r_sy      <= {ry[C-1], ry} - {ly[C-1], ly};
        r_tx      <= {r_px[C-1], r_px} - {lx[C-1], lx};
        r_ty      <= {r_py[C-1], r_py} - {ly[C-1], ly};

        r_m_last  <= r_d_last;
        r_m_span  <= r_d_span;
        r_m_below <= r_d_below;
        r_m_above <= r_d_above;
        r_p1      <= PW'(r_sx) * PW'(r_ty);
        r_p2      <= PW'(r_sy) * PW'(r_tx);

        if (load_out) begin
            r_out <= r_parity;
        end
    end

    assign o_valid      = r_out_vld;
    assign o_inside_res = r_out;

endmodule

FILE: sv/point_in_polygon_test.sv
// Top level of the crossing-number point-in-polygon tester.
`timescale 1ns / 1ps

// This block holds one polygon of up to MAX_VERTICES vertices and answers
// whether query points lie inside it, using an upward ray and the parity of
// the edges it crosses. Each item carries a function code and a signed
// COORD_BITS-bit coordinate pair: a start item clears the polygon and stores
// its first vertex, an append item adds a vertex and widens the bounding box
// (appends past capacity are dropped), and a query item returns exactly one
// result, o_inside_res. Code 3 is discarded and gives no result. A two-entry
// queue parts the input side from the processing side, so items are taken
// while earlier work is still under way. A query whose point falls outside
// the box, or that finds an empty polygon, is answered without a walk;
// otherwise the walker reads one vertex per cycle from the vertex store
// through its one read port and feeds one edge per cycle into the edge
// forming, classify and difference, and product stages, so the time a query
// holds the back part, from the cycle it leaves the queue to the cycle its
// answer is loaded, grows with the number of stored vertices and is set by
// that one store read port. Queries are handled one at a time. The cross
// product is exact, so results match a full-precision evaluation bit for bit.
// The vertex store needs no clearing after reset, since only stored vertices
// are ever read.
module point_in_polygon_test
    import pip_pkg::*;
#(
    parameter int MAX_VERTICES = 64,
    parameter int COORD_BITS   = 16
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_stall,
    input  logic [1:0]                   i_func,
    input  logic signed [COORD_BITS-1:0] i_coord_x,
    input  logic signed [COORD_BITS-1:0] i_coord_y,
    output logic                         o_valid,
    input  logic                         i_stall,
    output logic                         o_inside_res
);

    // Queue head as seen by the back part.
    t_head                        head;
    logic signed [COORD_BITS-1:0] head_x;
    logic signed [COORD_BITS-1:0] head_y;
    logic                         pop;

    // The front accepts every item while its queue has room and keeps
    // only the codes that mean something.
    pip_front #(
        .COORD_BITS (COORD_BITS)
    ) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .o_stall   (o_stall),
        .i_func    (i_func),
        .i_coord_x (i_coord_x),
        .i_coord_y (i_coord_y),
        .o_head    (head),
        .o_head_x  (head_x),
        .o_head_y  (head_y),
        .i_pop     (pop)
    );

    // The back updates the polygon, walks its edges for queries and holds
    // each answer in an output register until it is taken.
    pip_back #(
        .MAX_VERTICES (MAX_VERTICES),
        .COORD_BITS   (COORD_BITS)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head       (head),
        .i_head_x     (head_x),
        .i_head_y     (head_y),
        .o_pop        (pop),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_inside_res (o_inside_res)
    );

endmodule

FILE: sv/pip_checker.sv
// Port-level checks for the point-in-polygon tester, bound to the top level.
`timescale 1ns / 1ps
`include "point_in_polygon_test_defines.svh"

module pip_checker (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_stall,
    input  logic i_out_valid,
    input  logic i_out_stall,
    input  logic i_inside_res
);

    // A stalled result item stays on the port with the same value.
    property p_out_hold;
        (i_out_valid && i_out_stall) |=> (i_out_valid && $stable(i_inside_res));
    endproperty

    `PIP_CHECK_RUN(a_out_hold, p_out_hold, "stalled result item changed or vanished")
    `PIP_CHECK(a_rst_no_result, (!i_rst_n) |=> (!i_out_valid), "result item after reset")
    `PIP_CHECK(a_rst_queue_open, (!i_rst_n) |=> (!i_in_stall), "input stalled after reset")

endmodule

bind point_in_polygon_test pip_checker u_pip_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_stall   (o_stall),
    .i_out_valid  (o_valid),
    .i_out_stall  (i_stall),
    .i_inside_res (o_inside_res)
);

FILE: test/point_in_polygon_test_tb.sv
// Self-checking testbench for the point-in-polygon tester with a built-in polygon model.
`timescale 1ns / 1ps

module point_in_polygon_test_tb;
    import pip_pkg::*;

    localparam int MAX_VERTICES   = 64;
    localparam int COORD_BITS     = 16;
    localparam int ITEM_TARGET    = 1750;
    localparam int DRAIN_CYCLES   = 200;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int RESET_CYCLES   = 11;

    // Code 3 is not part of the package enum; the block drops such items.
    localparam logic [1:0] FN_UNUSED = 2'd3;

    localparam logic signed [COORD_BITS-1:0] C_MIN = 16'sh8000;
    localparam logic signed [COORD_BITS-1:0] C_MAX = 16'sh7fff;

    typedef struct {
        logic [1:0]                   func;
        logic signed [COORD_BITS-1:0] x;
        logic signed [COORD_BITS-1:0] y;
        bit                           typed;  // res below is the known answer
        bit                           res;
    } t_stim_row;

    typedef enum int {
        RX_FREE,
        RX_RANDOM,
        RX_LONG,
        RX_TOGGLE
    } t_rx_mode;

    logic                         i_clk     = 1'b0;
    logic                         i_rst_n   = 1'b0;
    logic                         i_valid   = 1'b0;
    logic [1:0]                   i_func    = 2'd0;
    logic signed [COORD_BITS-1:0] i_coord_x = '0;
    logic signed [COORD_BITS-1:0] i_coord_y = '0;
    logic                         i_stall   = 1'b0;
    logic                         o_stall;
    logic                         o_valid;
    logic                         o_inside_res;

    point_in_polygon_test #(
        .MAX_VERTICES(MAX_VERTICES),
        .COORD_BITS  (COORD_BITS)
    ) uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_func      (i_func),
        .i_coord_x   (i_coord_x),
        .i_coord_y   (i_coord_y),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_inside_res(o_inside_res)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Directed rows: empty polygon, box edges, single vertex, extreme square,
    // a small triangle, and the unused selector.
    t_stim_row directed_tbl [0:24] = '{
        '{FN_QUERY,  16'sd0,  16'sd0,  1'b1, 1'b0},  // empty polygon inside zero box
        '{FN_QUERY,  16'sd1,  16'sd0,  1'b1, 1'b0},  // just outside zero box
        '{FN_UNUSED, C_MIN,   C_MAX,   1'b0, 1'b0},
        '{FN_APPEND, C_MIN,   C_MIN,   1'b0, 1'b0},  // append onto empty store
        '{FN_QUERY,  C_MIN,   C_MIN,   1'b1, 1'b0},  // single vertex never counts
        '{FN_QUERY,  C_MAX,   C_MAX,   1'b1, 1'b0},  // outside one-point box
        '{FN_APPEND, C_MAX,   C_MIN,   1'b0, 1'b0},
        '{FN_APPEND, C_MAX,   C_MAX,   1'b0, 1'b0},
        '{FN_APPEND, C_MIN,   C_MAX,   1'b0, 1'b0},
        '{FN_QUERY,  16'sd0,  16'sd0,  1'b0, 1'b0},
        '{FN_QUERY,  C_MAX,   16'sd0,  1'b0, 1'b0},
        '{FN_QUERY,  C_MIN,   16'sd0,  1'b0, 1'b0},
        '{FN_QUERY,  16'sd0,  C_MAX,   1'b0, 1'b0},
        '{FN_QUERY,  16'sd0,  C_MIN,   1'b0, 1'b0},
        '{FN_QUERY,  -16'sd1, -16'sd1, 1'b0, 1'b0},
        '{FN_START,  16'sd10, 16'sd10, 1'b0, 1'b0},
        '{FN_APPEND, 16'sd20, 16'sd10, 1'b0, 1'b0},
        '{FN_APPEND, 16'sd15, 16'sd30, 1'b0, 1'b0},
        '{FN_QUERY,  16'sd15, 16'sd15, 1'b0, 1'b0},
        '{FN_QUERY,  16'sd21, 16'sd15, 1'b1, 1'b0},  // right of box
        '{FN_QUERY,  16'sd15, 16'sd31, 1'b1, 1'b0},  // above box
        '{FN_QUERY,  16'sd20, 16'sd30, 1'b0, 1'b0},  // box corner
        '{FN_QUERY,  16'sd12, 16'sd14, 1'b0, 1'b0},  // needs the cross product
        '{FN_UNUSED, 16'sd0,  16'sd0,  1'b0, 1'b0},
        '{FN_QUERY,  16'sd10, 16'sd10, 1'b0, 1'b0}
    };

    t_stim_row stim_q [$];
    int        live_items;

    // Polygon model state.
    logic signed [COORD_BITS-1:0] poly_x [MAX_VERTICES];
    logic signed [COORD_BITS-1:0] poly_y [MAX_VERTICES];
    int                           poly_len;
    logic signed [COORD_BITS-1:0] box_lo_x, box_lo_y, box_hi_x, box_hi_y;

    bit pending_inside [$];

    int fail_count;
    int polygons_started;
    int queries_sent;
    int inside_seen;
    int appends_dropped;
    int ignored_items;
    int results_seen;

    function automatic bit crossing_parity(logic signed [COORD_BITS-1:0] px,
                                           logic signed [COORD_BITS-1:0] py);
        int                           hits;
        int                           j;
        logic signed [COORD_BITS-1:0] lx, ly, rx, ry, tmp;
        longint                       sx, sy, tx, ty;
        hits = 0;
        if (px < box_lo_x || px > box_hi_x || py < box_lo_y || py > box_hi_y) begin
            return 1'b0;
        end
        for (int i = 0; i < poly_len; i++) begin
            j  = (i + 1 >= poly_len) ? 0 : i + 1;
            lx = poly_x[i];
            ly = poly_y[i];
            rx = poly_x[j];
            ry = poly_y[j];
            if (lx > rx) begin
                tmp = lx; lx = rx; rx = tmp;
                tmp = ly; ly = ry; ry = tmp;
            end
            if (lx > px || rx <= px) continue;
            if (ly < py && ry < py) continue;
            if (ly >= py && ry >= py) begin
                hits++;
                continue;
            end
            sx = longint'(rx) - longint'(lx);
            sy = longint'(ry) - longint'(ly);
            tx = longint'(px) - longint'(lx);
            ty = longint'(py) - longint'(ly);
            if (sx * ty < sy * tx) hits++;
        end
        return hits[0];
    endfunction

    // Applies one accepted item to the polygon model and, for a query, queues its answer.
    task automatic polygon_step(t_stim_row row);
        bit answer;
        case (row.func)
            FN_START: begin
                poly_x[0] = row.x;
                poly_y[0] = row.y;
                poly_len  = 1;
                box_lo_x  = row.x;
                box_hi_x  = row.x;
                box_lo_y  = row.y;
                box_hi_y  = row.y;
                polygons_started++;
            end
            FN_APPEND: begin
                if (poly_len >= MAX_VERTICES) begin
                    appends_dropped++;
                end else begin
                    poly_x[poly_len] = row.x;
                    poly_y[poly_len] = row.y;
                    if (poly_len == 0) begin
                        box_lo_x = row.x;
                        box_hi_x = row.x;
                        box_lo_y = row.y;
                        box_hi_y = row.y;
                    end else begin
                        if (row.x < box_lo_x) box_lo_x = row.x;
                        if (row.y < box_lo_y) box_lo_y = row.y;
                        if (row.x > box_hi_x) box_hi_x = row.x;
                        if (row.y > box_hi_y) box_hi_y = row.y;
                    end
                    poly_len++;
                end
            end
            FN_QUERY: begin
                answer = row.typed ? row.res : crossing_parity(row.x, row.y);
                pending_inside.insert(pending_inside.size(), answer);
                queries_sent++;
            end
            default: begin
                ignored_items++;
            end
        endcase
    endtask

    task automatic add_row(logic [1:0] f, logic signed [COORD_BITS-1:0] x,
                           logic signed [COORD_BITS-1:0] y);
        t_stim_row row;
        row.func  = f;
        row.x     = x;
        row.y     = y;
        row.typed = 1'b0;
        row.res   = 1'b0;
        stim_q.insert(stim_q.size(), row);
        if (f != FN_UNUSED) live_items++;
    endtask

    task automatic add_noise();
        if ($urandom_range(0, 19) == 0) begin
            add_row(FN_UNUSED, COORD_BITS'($urandom_range(0, 65535)),
                    COORD_BITS'($urandom_range(0, 65535)));
        end
    endtask

    function automatic logic signed [COORD_BITS-1:0] pick_coord(int base, int span);
        int v;
        if (span >= 32767) begin
            v = int'($urandom_range(0, 65535)) - 32768;
        end else begin
            v = base + int'($urandom_range(0, 2 * span)) - span;
            if (v > 32767) v = 32767;
            if (v < -32768) v = -32768;
        end
        return v[COORD_BITS-1:0];
    endfunction

    // One polygon with random content followed by queries aimed at its
    // interior, its vertices, its edges and its surroundings.
    task automatic add_polygon(bit big);
        int                           span, base_x, base_y, nv, nq, k, k1, r;
        int                           gx [$];
        int                           gy [$];
        logic signed [COORD_BITS-1:0] x, y;
        logic [1:0]                   first_fn;
        case ($urandom_range(0, 3))
            0:       span = 32767;
            1:       span = 2000;
            2:       span = 60;
            default: span = 6;
        endcase
        base_x = int'($urandom_range(0, 65535)) - 32768;
        base_y = int'($urandom_range(0, 65535)) - 32768;
        r = $urandom_range(0, 99);
        if (big || r >= 95) nv = $urandom_range(60, 70);
        else if (r >= 80)   nv = $urandom_range(11, 40);
        else                nv = $urandom_range(1, 10);
        // Now and then the polygon goes on from the previous one instead.
        first_fn = ($urandom_range(0, 29) == 0) ? FN_APPEND : FN_START;
        for (k = 0; k < nv; k++) begin
            x = pick_coord(base_x, span);
            y = pick_coord(base_y, span);
            add_noise();
            add_row((k == 0) ? first_fn : FN_APPEND, x, y);
            gx.insert(gx.size(), int'(x));
            gy.insert(gy.size(), int'(y));
        end
        nq = $urandom_range(1, 8);
        for (int q = 0; q < nq; q++) begin
            k  = $urandom_range(0, gx.size() - 1);
            k1 = (k + 1 >= gx.size()) ? 0 : k + 1;
            r  = $urandom_range(0, 9);
            if (r <= 4) begin
                x = pick_coord(base_x, span);
                y = pick_coord(base_y, span);
            end else if (r <= 6) begin
                x = COORD_BITS'(gx[k]);
                y = COORD_BITS'(gy[k]);
            end else if (r == 7) begin
                x = COORD_BITS'((gx[k] + gx[k1]) / 2);
                y = COORD_BITS'((gy[k] + gy[k1]) / 2);
            end else if (r == 8) begin
                x = COORD_BITS'(gx[k]);
                y = pick_coord(base_y, span);
            end else begin
                x = pick_coord(0, 32767);
                y = pick_coord(0, 32767);
            end
            add_noise();
            add_row(FN_QUERY, x, y);
            if ($urandom_range(0, 19) == 0) begin
                x = pick_coord(base_x, span);
                y = pick_coord(base_y, span);
                add_row(FN_APPEND, x, y);
                gx.insert(gx.size(), int'(x));
                gy.insert(gy.size(), int'(y));
            end
        end
    endtask

    // Sender: bursts of items with random gaps in between.
    t_stim_row cur_row;
    int        next_idx;
    int        accepted;
    int        burst_left;
    int        gap_left;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid    <= 1'b0;
            i_func     <= FN_START;
            i_coord_x  <= '0;
            i_coord_y  <= '0;
            burst_left = $urandom_range(1, 40);
            gap_left   = 0;
        end else begin
            if (i_valid && !o_stall) begin
                polygon_step(cur_row);
                accepted++;
            end
            if (!i_valid || !o_stall) begin
                if (gap_left > 0) begin
                    gap_left--;
                    i_valid <= 1'b0;
                end else if (next_idx < stim_q.size()) begin
                    cur_row = stim_q[next_idx];
                    next_idx++;
                    i_valid   <= 1'b1;
                    i_func    <= cur_row.func;
                    i_coord_x <= cur_row.x;
                    i_coord_y <= cur_row.y;
                    if (burst_left > 1) begin
                        burst_left--;
                    end else begin
                        burst_left = $urandom_range(1, 40);
                        case ($urandom_range(0, 19))
                            0, 1, 2, 3, 4, 5, 6, 7, 8, 9: gap_left = 0;
                            10, 11, 12, 13, 14, 15:       gap_left = $urandom_range(1, 3);
                            16, 17, 18:                   gap_left = $urandom_range(4, 12);
                            default:                      gap_left = $urandom_range(13, 40);
                        endcase
                    end
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver: stall pattern that switches between free flow, random
    // stalls, long stall runs and a strict toggle.
    t_rx_mode rx_mode;
    int       rx_mode_left;
    int       rx_run_left;
    bit       rx_hold;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall      <= 1'b0;
            rx_mode      = RX_FREE;
            rx_mode_left = 0;
            rx_run_left  = 0;
            rx_hold      = 1'b0;
        end else begin
            if (rx_mode_left == 0) begin
                rx_mode      = t_rx_mode'($urandom_range(0, 3));
                rx_mode_left = $urandom_range(20, 400);
            end else begin
                rx_mode_left--;
            end
            case (rx_mode)
                RX_FREE:   i_stall <= 1'b0;
                RX_RANDOM: i_stall <= ($urandom_range(0, 3) == 0);
                RX_LONG: begin
                    if (rx_run_left == 0) begin
                        rx_hold     = !rx_hold;
                        rx_run_left = rx_hold ? $urandom_range(1, 30) : $urandom_range(1, 8);
                    end else begin
                        rx_run_left--;
                    end
                    i_stall <= rx_hold;
                end
                default:   i_stall <= ~i_stall;
            endcase
        end
    end

    // Every accepted result is matched against the oldest queued answer.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid === 1'b1 && i_stall === 1'b0) begin
            results_seen++;
            if (pending_inside.size() == 0) begin
                $error("inside_res arrived with no query waiting: actual %0b", o_inside_res);
                fail_count++;
            end else begin
                if (o_inside_res !== pending_inside[0]) begin
                    $error("inside_res mismatch: expected %0b, actual %0b",
                           pending_inside[0], o_inside_res);
                    fail_count++;
                end
                if (o_inside_res === 1'b1) inside_seen++;
                void'(pending_inside.pop_front());
            end
        end
    end

    // Ends the run if nothing moves on either channel for too long.
    int idle_cycles;

    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid === 1'b1 && !i_stall)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Watchdog expired after %0d idle cycles, %0d answers outstanding.",
                     idle_cycles, pending_inside.size());
            $display("point_in_polygon_test regression: fail");
            $finish;
        end
    end

    initial begin
        poly_len = 0;
        box_lo_x = '0;
        box_lo_y = '0;
        box_hi_x = '0;
        box_hi_y = '0;
        foreach (directed_tbl[n]) begin
            stim_q.insert(stim_q.size(), directed_tbl[n]);
            if (directed_tbl[n].func != FN_UNUSED) live_items++;
        end
        // A polygon that may overrun the store comes first and another near the end.
        add_polygon(1'b1);
        while (live_items < ITEM_TARGET - 80) add_polygon(1'b0);
        add_polygon(1'b1);
        while (live_items < ITEM_TARGET) add_polygon(1'b0);

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (accepted < stim_q.size()) @(posedge i_clk);
        while (pending_inside.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (pending_inside.size() != 0) begin
            $error("%0d inside_res answers never arrived", pending_inside.size());
            fail_count++;
        end
        $display("Ran %0d items over %0d polygons: %0d queries answered, %0d inside,",
                 accepted, polygons_started, results_seen, inside_seen);
        $display("%0d appends dropped at a full store, %0d unused-code items ignored.",
                 appends_dropped, ignored_items);
        if (fail_count == 0) begin
            $display("point_in_polygon_test regression: pass");
        end else begin
            $display("point_in_polygon_test regression: fail");
        end
        $finish;
    end

endmodule
